@@ design/ust_pkg.sv @@
`timescale 1ns / 1ps
package ust_pkg;

  localparam int unsigned CP_W       = 32;
  localparam int unsigned FMT_W      = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 3;
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_PTR_W    = 2;
  localparam int unsigned Q_CNT_W    = 3;

  localparam logic [FMT_W-1:0] FMT_UTF8  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_U16LE = 3'd1;
  localparam logic [FMT_W-1:0] FMT_U16BE = 3'd2;
  localparam logic [FMT_W-1:0] FMT_U32LE = 3'd3;
  localparam logic [FMT_W-1:0] FMT_U32BE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_FORMAT = 1'd1;

  localparam logic [CP_W-1:0] CP_BOM = 32'h0000_FEFF;

  typedef struct packed {
    logic [CP_W-1:0] cp;
  } cp_item_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last;
  } enc_t;

  // Codes past the last format fall back to UTF-8.
  function automatic logic [FMT_W-1:0] fmt_norm(input logic [FMT_W-1:0] f);
    fmt_norm = (f > FMT_U32BE) ? FMT_UTF8 : f;
  endfunction

  function automatic logic [2:0] unit_length(input logic [FMT_W-1:0] fmt,
                                             input logic [7:0] first);
    logic [2:0] n;
    n = 3'd4;
    case (fmt)
      FMT_UTF8: begin
        if (first[7:3] == 5'b11110) n = 3'd4;
        else if (first[7:4] == 4'b1110) n = 3'd3;
        else if (first[7:5] == 3'b110) n = 3'd2;
        else n = 3'd1;
      end
      FMT_U16LE, FMT_U16BE: n = 3'd2;
      default: n = 3'd4;
    endcase
    unit_length = n;
  endfunction

  function automatic enc_t encode(input logic [CP_W-1:0] v, input logic [FMT_W-1:0] fmt);
    enc_t e;
    logic [19:0] w;
    logic [15:0] u0;
    logic [15:0] u1;
    logic big;
    e = '0;
    big = |v[31:16];
    w = v[19:0] - 20'h10000;
    u0 = big ? {6'b110110, w[19:10]} : v[15:0];
    u1 = {6'b110111, w[9:0]};
    case (fmt)
      FMT_U16LE: begin
        e.bytes[0] = u0[7:0];
        e.bytes[1] = u0[15:8];
        e.bytes[2] = u1[7:0];
        e.bytes[3] = u1[15:8];
        e.last = big ? 2'd3 : 2'd1;
      end
      FMT_U16BE: begin
        e.bytes[0] = u0[15:8];
        e.bytes[1] = u0[7:0];
        e.bytes[2] = u1[15:8];
        e.bytes[3] = u1[7:0];
        e.last = big ? 2'd3 : 2'd1;
      end
      FMT_U32LE: begin
        e.bytes = {v[31:24], v[23:16], v[15:8], v[7:0]};
        e.last = 2'd3;
      end
      FMT_U32BE: begin
        e.bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
        e.last = 2'd3;
      end
      default: begin
        if (big) begin
          e.bytes[0] = {5'b11110, v[20:18]};
          e.bytes[1] = {2'b10, v[17:12]};
          e.bytes[2] = {2'b10, v[11:6]};
          e.bytes[3] = {2'b10, v[5:0]};
          e.last = 2'd3;
        end else if (|v[15:11]) begin
          e.bytes[0] = {4'b1110, v[15:12]};
          e.bytes[1] = {2'b10, v[11:6]};
          e.bytes[2] = {2'b10, v[5:0]};
          e.last = 2'd2;
        end else if (|v[10:7]) begin
          e.bytes[0] = {3'b110, v[10:6]};
          e.bytes[1] = {2'b10, v[5:0]};
          e.last = 2'd1;
        end else begin
          e.bytes[0] = v[7:0];
          e.last = 2'd0;
        end
      end
    endcase
    encode = e;
  endfunction

endpackage

@@ design/ust_in_if.sv @@
`timescale 1ns / 1ps
interface ust_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

@@ design/ust_out_if.sv @@
`timescale 1ns / 1ps
interface ust_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input string_end,
                output ready);
endinterface

@@ design/utf_stream_transcoder.sv @@
`timescale 1ns / 1ps
// Byte stream transcoder between UTF-8, UTF-16 LE/BE and UTF-32 LE/BE.
// in_s carries one source byte per word; out_s carries one target byte per
// word with run_last on the final byte of a code point and string_end on
// every byte of an encoded zero terminator. A leading U+FEFF of a string is
// dropped. cfg_we/cfg_index/cfg_wdata write source_format (index 0) and
// target_format (index 1); write them only while the block is idle. A write
// to source_format drops any partial unit and held surrogate.
// Throughput: one input byte per cycle while the queue has room and one output
// byte per cycle while out_s is ready; a code point that expands into N target
// bytes occupies the encoder until all N have gone out, and the four-entry code
// point queue absorbs the difference before in_s ready drops. The first byte of a
// code point passes the queue, the encoder register and the output register.
// Reset (rst_n low, synchronous) empties the queue and the output register
// and returns to the start of a string; no clearing pass is needed.
// When out_s stalls the output word holds, the encoder waits, the queue
// fills, and then in_s ready goes low.
module utf_stream_transcoder import ust_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ust_in_if.sink                in_s,
  ust_out_if.source             out_s,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [FMT_W-1:0] src_fmt_r;
  logic [FMT_W-1:0] tgt_fmt_r;
  logic             src_clear;
  logic             in_take;
  logic             push;
  cp_item_t         push_item;
  logic             q_full;
  logic             q_nonempty;
  logic             q_pop;
  cp_item_t         q_head;

  assign src_clear = cfg_we && (cfg_index == REG_SOURCE_FORMAT);
  assign in_s.ready = !q_full;
  assign in_take = in_s.valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= FMT_UTF8;
      tgt_fmt_r <= FMT_UTF8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_FORMAT: src_fmt_r <= cfg_wdata;
        REG_TARGET_FORMAT: tgt_fmt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ust_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_fmt   (src_fmt_r),
    .src_clear (src_clear),
    .in_take   (in_take),
    .in_byte   (in_s.in_byte),
    .push      (push),
    .push_item (push_item)
  );

  ust_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  ust_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tgt_fmt    (tgt_fmt_r),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_s.valid),
    .out_ready  (out_s.ready),
    .out_byte   (out_s.out_byte),
    .run_last   (out_s.run_last),
    .string_end (out_s.string_end)
  );

endmodule

@@ design/ust_front.sv @@
`timescale 1ns / 1ps
module ust_front import ust_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [FMT_W-1:0] src_fmt,
  input  logic             src_clear,
  input  logic             in_take,
  input  logic [7:0]       in_byte,
  output logic             push,
  output cp_item_t         push_item
);

  logic [1:0]        seen_r, seen_nxt;
  logic [2:0]        need_r, need_nxt;
  logic [3:0][7:0]   unit_r, unit_nxt;
  logic [9:0]        high_r, high_nxt;
  logic              pend_r, pend_nxt;
  logic              start_r, start_nxt;

  logic [FMT_W-1:0]  fmt;
  logic [2:0]        need;
  logic              done;
  logic [3:0][7:0]   p;
  logic [15:0]       unit16;
  logic [CP_W-1:0]   cp;
  logic              cp_ok;

  always_comb begin
    fmt = fmt_norm(src_fmt);
    need = (seen_r == 2'd0) ? unit_length(fmt, in_byte) : need_r;
    done = ({1'b0, seen_r} + 3'd1) == need;
    p = unit_r;
    p[seen_r] = in_byte;
    unit16 = (fmt == FMT_U16LE) ? {p[1], p[0]} : {p[0], p[1]};

    seen_nxt  = seen_r;
    need_nxt  = need_r;
    unit_nxt  = unit_r;
    high_nxt  = high_r;
    pend_nxt  = pend_r;
    start_nxt = start_r;
    cp        = '0;
    cp_ok     = 1'b0;
    push      = 1'b0;

    case (fmt)
      FMT_U16LE, FMT_U16BE: begin
        if (pend_r) begin
          cp = {12'd0, high_r, unit16[9:0]} + 32'h0001_0000;
          cp_ok = 1'b1;
        end else if (unit16[15:10] == 6'b110110) begin
          cp_ok = 1'b0;
        end else begin
          cp = {16'd0, unit16};
          cp_ok = 1'b1;
        end
      end
      FMT_U32LE: begin
        cp = {p[3], p[2], p[1], p[0]};
        cp_ok = 1'b1;
      end
      FMT_U32BE: begin
        cp = {p[0], p[1], p[2], p[3]};
        cp_ok = 1'b1;
      end
      default: begin
        case (need)
          3'd4: cp = {11'd0, p[0][2:0], p[1][5:0], p[2][5:0], p[3][5:0]};
          3'd3: cp = {16'd0, p[0][3:0], p[1][5:0], p[2][5:0]};
          3'd2: cp = {21'd0, p[0][4:0], p[1][5:0]};
          default: cp = {24'd0, p[0]};
        endcase
        cp_ok = 1'b1;
      end
    endcase

    if (src_clear) begin
      seen_nxt = '0;
      need_nxt = '0;
      pend_nxt = 1'b0;
      high_nxt = '0;
    end else if (in_take) begin
      unit_nxt = p;
      need_nxt = need;
      seen_nxt = done ? 2'd0 : seen_r + 2'd1;
      if (done) begin
        if ((fmt == FMT_U16LE || fmt == FMT_U16BE) && !pend_r && !cp_ok) begin
          // hold the high half until the low unit arrives
          high_nxt = unit16[9:0];
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (start_r && cp == CP_BOM) begin
            start_nxt = 1'b0;
          end else begin
            start_nxt = (cp == '0);
            push = 1'b1;
          end
        end
      end
    end
    push_item.cp = cp;
  end

  always_ff @(posedge clk) begin
    unit_r <= unit_nxt;
    if (!rst_n) begin
      seen_r  <= '0;
      need_r  <= '0;
      high_r  <= '0;
      pend_r  <= 1'b0;
      start_r <= 1'b1;
    end else begin
      seen_r  <= seen_nxt;
      need_r  <= need_nxt;
      high_r  <= high_nxt;
      pend_r  <= pend_nxt;
      start_r <= start_nxt;
    end
  end

`ifndef SYNTHESIS
  a_seen_below_need: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r != 2'd0 |-> {1'b0, seen_r} < need_r)
    else $error("unit byte count passed unit length");
`endif

endmodule

@@ design/ust_queue.sv @@
`timescale 1ns / 1ps
module ust_queue import ust_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  cp_item_t push_item,
  input  logic     pop,
  output logic     full,
  output logic     nonempty,
  output cp_item_t head
);

  cp_item_t [Q_DEPTH-1:0] mem_r;
  logic [Q_PTR_W-1:0]     wr_r, wr_nxt;
  logic [Q_PTR_W-1:0]     rd_r, rd_nxt;
  logic [Q_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                   do_pop;

  assign full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rd_r];
  assign do_pop   = pop && nonempty;

  always_comb begin
    wr_nxt  = push ? wr_r + Q_PTR_W'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + Q_PTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("word pushed into full queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

@@ design/ust_back.sv @@
`timescale 1ns / 1ps
module ust_back import ust_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [FMT_W-1:0] tgt_fmt,
  input  logic             q_nonempty,
  input  cp_item_t         q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             string_end
);

  logic            busy_r;
  enc_t            enc_r;
  logic [1:0]      pos_r;
  logic            end_r;
  logic            ov_r;
  logic [7:0]      ob_r;
  logic            ol_r;
  logic            oe_r;

  logic            adv;
  logic            emit;
  logic            last_emit;
  logic            load;

  always_comb begin
    adv       = !ov_r || out_ready;
    emit      = busy_r && adv;
    last_emit = emit && (pos_r == enc_r.last);
    load      = q_nonempty && (!busy_r || last_emit);
    q_pop     = load;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ob_r <= enc_r.bytes[pos_r];
      ol_r <= (pos_r == enc_r.last);
      oe_r <= end_r;
    end
    if (load) begin
      enc_r <= encode(q_head.cp, fmt_norm(tgt_fmt));
      end_r <= (q_head.cp == '0);
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (emit) ov_r <= 1'b1;
      else if (adv) ov_r <= 1'b0;
      if (load) begin
        busy_r <= 1'b1;
        pos_r  <= '0;
      end else begin
        if (last_emit) busy_r <= 1'b0;
        if (emit) pos_r <= pos_r + 2'd1;
      end
    end
  end

  assign out_valid  = ov_r;
  assign out_byte   = ob_r;
  assign run_last   = ol_r;
  assign string_end = oe_r;

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pos_r <= enc_r.last)
    else $error("byte index past encoding");
  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oe_r |-> ob_r == 8'd0)
    else $error("terminator word not zero");
`endif

endmodule

@@ bench/tb_utf_stream_transcoder.sv @@
`timescale 1ns / 1ps
module tb_utf_stream_transcoder;
  import ust_pkg::*;

  localparam logic [FMT_W-1:0] FMT_SPARE_LO = 3'd5;
  localparam logic [FMT_W-1:0] FMT_SPARE_HI = 3'd7;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_BYTES   = 32;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STUCK_LIMIT   = 400;

  localparam logic [FMT_W-1:0] SRC_PLAN [6] = '{FMT_UTF8, FMT_U32BE, FMT_U16LE, FMT_U16BE,
                                                 FMT_U32LE, FMT_SPARE_HI};
  localparam logic [FMT_W-1:0] TGT_PLAN [6] = '{FMT_U32BE, FMT_UTF8, FMT_U16BE, FMT_U16LE,
                                                 FMT_SPARE_LO, FMT_U32LE};

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } tgt_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ust_in_if  src_ch();
  ust_out_if tgt_ch();

  utf_stream_transcoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (src_ch),
    .out_s     (tgt_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Transcoder state as the block should hold it
  logic [FMT_W-1:0] src_fmt = FMT_UTF8;
  logic [FMT_W-1:0] tgt_fmt = FMT_UTF8;
  logic [7:0]       unit_buf [4];
  logic [2:0]       unit_seen = '0;
  logic [2:0]       unit_len = '0;
  logic [9:0]       held_high = '0;
  logic             high_held = 1'b0;
  logic             str_start = 1'b1;

  tgt_word_t   expected_words[$];
  logic [7:0]  source_bytes[$];
  int unsigned mismatches = 0;
  bit          idle_on = 1'b0;
  int unsigned stall_left = 0;

  // Bytes of one code point in a given form; seq[0] goes out first.
  function automatic int unsigned to_bytes(input logic [31:0] cp, input logic [FMT_W-1:0] fmt_in,
                                           output logic [3:0][7:0] seq);
    logic [FMT_W-1:0] fmt;
    logic [31:0] w;
    logic [15:0] hi;
    logic [15:0] lo;
    bit          pair;
    int unsigned n;
    fmt = (fmt_in > FMT_U32BE) ? FMT_UTF8 : fmt_in;
    seq = '0;
    pair = (cp > 32'hFFFF);
    w = cp - 32'h10000;
    hi = pair ? {6'b110110, w[19:10]} : cp[15:0];
    lo = {6'b110111, w[9:0]};
    case (fmt)
      FMT_U16LE: begin
        seq = {lo[15:8], lo[7:0], hi[15:8], hi[7:0]};
        n = pair ? 4 : 2;
      end
      FMT_U16BE: begin
        seq = {lo[7:0], lo[15:8], hi[7:0], hi[15:8]};
        n = pair ? 4 : 2;
      end
      FMT_U32LE: begin
        seq = cp;
        n = 4;
      end
      FMT_U32BE: begin
        seq = {cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
        n = 4;
      end
      default: begin
        if (pair) begin
          seq[0] = {5'b11110, cp[20:18]};
          seq[1] = {2'b10, cp[17:12]};
          seq[2] = {2'b10, cp[11:6]};
          seq[3] = {2'b10, cp[5:0]};
          n = 4;
        end else if (cp > 32'h7FF) begin
          seq[0] = {4'b1110, cp[15:12]};
          seq[1] = {2'b10, cp[11:6]};
          seq[2] = {2'b10, cp[5:0]};
          n = 3;
        end else if (cp > 32'h7F) begin
          seq[0] = {3'b110, cp[10:6]};
          seq[1] = {2'b10, cp[5:0]};
          n = 2;
        end else begin
          seq[0] = cp[7:0];
          n = 1;
        end
      end
    endcase
    return n;
  endfunction

  function automatic void take_source_byte(input logic [7:0] b);
    logic [FMT_W-1:0] fmt;
    logic [15:0]      unit;
    logic [31:0]      cp;
    logic [3:0][7:0]  seq;
    int unsigned      n;
    int unsigned      k;
    fmt = (src_fmt > FMT_U32BE) ? FMT_UTF8 : src_fmt;
    if (unit_seen == 3'd0) begin
      if (fmt == FMT_U16LE || fmt == FMT_U16BE) unit_len = 3'd2;
      else if (fmt != FMT_UTF8) unit_len = 3'd4;
      else if (b[7:3] == 5'b11110) unit_len = 3'd4;
      else if (b[7:4] == 4'b1110) unit_len = 3'd3;
      else if (b[7:5] == 3'b110) unit_len = 3'd2;
      else unit_len = 3'd1;
    end
    unit_buf[unit_seen[1:0]] = b;
    unit_seen = unit_seen + 3'd1;
    if (unit_seen < unit_len) return;
    unit_seen = 3'd0;

    case (fmt)
      FMT_U16LE, FMT_U16BE: begin
        unit = (fmt == FMT_U16LE) ? {unit_buf[1], unit_buf[0]} : {unit_buf[0], unit_buf[1]};
        if (high_held) begin
          // whatever follows a high surrogate is its low half
          cp = {12'd0, held_high, unit[9:0]} + 32'h10000;
          high_held = 1'b0;
        end else if (unit[15:10] == 6'b110110) begin
          held_high = unit[9:0];
          high_held = 1'b1;
          return;
        end else begin
          cp = {16'd0, unit};
        end
      end
      FMT_U32LE: cp = {unit_buf[3], unit_buf[2], unit_buf[1], unit_buf[0]};
      FMT_U32BE: cp = {unit_buf[0], unit_buf[1], unit_buf[2], unit_buf[3]};
      default: begin
        case (unit_len)
          3'd4: cp = {11'd0, unit_buf[0][2:0], unit_buf[1][5:0], unit_buf[2][5:0],
                      unit_buf[3][5:0]};
          3'd3: cp = {16'd0, unit_buf[0][3:0], unit_buf[1][5:0], unit_buf[2][5:0]};
          3'd2: cp = {21'd0, unit_buf[0][4:0], unit_buf[1][5:0]};
          default: cp = {24'd0, unit_buf[0]};
        endcase
      end
    endcase

    // drop a byte order mark that opens a string
    if (str_start && cp == CP_BOM) begin
      str_start = 1'b0;
      return;
    end
    str_start = (cp == 32'd0);
    n = to_bytes(cp, tgt_fmt, seq);
    for (k = 0; k < n; k++)
      expected_words.push_back('{seq[k], k == n - 1, cp == 32'd0});
  endfunction

  function automatic void queue_code_point(input logic [31:0] cp, input logic [FMT_W-1:0] fmt,
                                           input bit cut);
    logic [3:0][7:0] seq;
    int unsigned     n;
    int unsigned     k;
    n = to_bytes(cp, fmt, seq);
    if (cut && n > 1) n--;
    for (k = 0; k < n; k++) source_bytes.push_back(seq[k]);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%02h, got 0x%02h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && src_ch.valid && src_ch.ready) take_source_byte(src_ch.in_byte);
  end

  always @(posedge clk) begin
    if (rst_n && tgt_ch.valid && tgt_ch.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: expected no word, got out_byte 0x%02h run_last %0b string_end %0b",
                 $time, tgt_ch.out_byte, tgt_ch.run_last, tgt_ch.string_end);
        mismatches++;
      end else begin
        check_field("out_byte", expected_words[0].out_byte, tgt_ch.out_byte);
        check_field("run_last", expected_words[0].run_last, tgt_ch.run_last);
        check_field("string_end", expected_words[0].string_end, tgt_ch.string_end);
        void'(expected_words.pop_front());
      end
    end
  end

  // Result-side stalls: random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      tgt_ch.ready <= (stall_left == 0);
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 17);
      tgt_ch.ready <= 1'b0;
    end else begin
      tgt_ch.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((src_ch.valid && src_ch.ready) || (tgt_ch.valid && tgt_ch.ready)) stuck = 0;
      else stuck++;
    end
    $display("tb_utf_stream_transcoder NOT OK");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      src_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_ch.valid <= 1'b1;
    src_ch.in_byte <= b;
    do @(posedge clk); while (!src_ch.ready);
  endtask

  // Drop valid, wait for every expected word, then let the pipeline drain.
  task automatic settle();
    src_ch.valid <= 1'b0;
    // let the checker take the last accepted byte first
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SOURCE_FORMAT) begin
      src_fmt = val;
      unit_seen = 3'd0;
      unit_len = 3'd0;
      high_held = 1'b0;
      held_high = '0;
    end else begin
      tgt_fmt = val;
    end
    @(posedge clk);
  endtask

  // Reset formats: leading BOM, one code point per UTF-8 length, stray bytes, terminator
  task automatic test_utf8_lengths();
    logic [7:0] stim [15] = '{8'hEF, 8'hBB, 8'hBF, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80,
                              8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80, 8'hFF, 8'h00};
    idle_on = 1'b1;
    foreach (stim[i]) send_byte(stim[i]);
    settle();
  endtask

  // Surrogate pair, a high surrogate left held, then a source switch that drops it
  task automatic test_surrogates();
    logic [7:0] pair_stim [6] = '{8'h00, 8'hD8, 8'h00, 8'hDC, 8'h00, 8'hD8};
    logic [7:0] wide_stim [4] = '{8'h00, 8'h01, 8'hF6, 8'h00};
    write_reg(REG_TARGET_FORMAT, FMT_U32LE);
    write_reg(REG_SOURCE_FORMAT, FMT_U16LE);
    foreach (pair_stim[i]) send_byte(pair_stim[i]);
    settle();
    write_reg(REG_SOURCE_FORMAT, FMT_U32BE);
    foreach (wide_stim[i]) send_byte(wide_stim[i]);
    settle();
  endtask

  task automatic test_random_streams();
    logic [31:0]      cp;
    logic [FMT_W-1:0] src;
    logic [FMT_W-1:0] tgt;
    int unsigned      kind;
    int unsigned      ph;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      src = (ph < 6) ? SRC_PLAN[ph] : FMT_W'($urandom_range(0, 7));
      tgt = (ph < 6) ? TGT_PLAN[ph] : FMT_W'($urandom_range(0, 7));
      if (ph < 6 || $urandom_range(0, 2) != 0) write_reg(REG_SOURCE_FORMAT, src);
      write_reg(REG_TARGET_FORMAT, tgt);
      src = src_fmt;
      idle_on = (ph != 2) && (ph < RANDOM_PHASES - 2);
      while (source_bytes.size() < PHASE_BYTES) begin
        if ($urandom_range(0, 2) == 0) queue_code_point(CP_BOM, src, 1'b0);
        repeat ($urandom_range(1, 6)) begin
          kind = $urandom_range(0, 11);
          case (kind)
            0, 1, 2: cp = $urandom_range(1, 'h7F);
            3:       cp = $urandom_range('h80, 'h7FF);
            4, 5:    cp = $urandom_range('h800, 'hFFFF);
            6, 7:    cp = $urandom_range('h10000, 'h10FFFF);
            8:       cp = (src == FMT_U32LE || src == FMT_U32BE) ? $urandom()
                                                               : $urandom_range('h110000, 'h1FFFFF);
            9:       cp = CP_BOM;
            default: cp = '0;
          endcase
          // noise bytes, or a code point that is sometimes cut short
          if (kind >= 10) repeat ($urandom_range(1, 3)) source_bytes.push_back(8'($urandom()));
          else queue_code_point(cp, src, $urandom_range(0, 11) == 0);
        end
        queue_code_point('0, src, 1'b0);
      end
      while (source_bytes.size() != 0) send_byte(source_bytes.pop_front());
      settle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SOURCE_FORMAT;
    cfg_wdata = FMT_UTF8;
    src_ch.valid = 1'b0;
    src_ch.in_byte = 8'h00;
    tgt_ch.ready = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_utf8_lengths();
    test_surrogates();
    test_random_streams();

    if (mismatches == 0) begin
      $display("tb_utf_stream_transcoder OK");
    end else begin
      $display("tb_utf_stream_transcoder NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/ust_pkg.sv
design/ust_in_if.sv
design/ust_out_if.sv
design/ust_front.sv
design/ust_queue.sv
design/ust_back.sv
design/utf_stream_transcoder.sv
bench/tb_utf_stream_transcoder.sv
